### src/assert_macros.svh
// assertion macros shared by the display buffer rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### src/cdbc_pkg.sv
// package for the character display buffer controller
// holds sizes, command codes, shared structs and address helpers; no dependencies

package cdbc_pkg;

    localparam int COLUMNS   = 16;
    localparam int COL_W     = $clog2(COLUMNS);
    localparam int NCELLS    = 2 * COLUMNS;
    localparam int IDX_W     = $clog2(NCELLS);
    localparam int ADDR_W    = 7;
    localparam int OP_W      = 3;
    localparam int CHAR_W    = 8;
    localparam int COLUMN_W  = 4;

    typedef logic [COL_W-1:0]    col_t;
    typedef logic [IDX_W-1:0]    idx_t;
    typedef logic [ADDR_W-1:0]   addr_t;
    typedef logic [CHAR_W-1:0]   char_t;
    typedef logic [COLUMN_W-1:0] column_t;

    localparam addr_t ROW1_BASE = addr_t'(7'h40);
    localparam char_t SPACE     = char_t'(8'h20);
    localparam col_t  LAST_COL  = col_t'(COLUMNS - 1);
    localparam addr_t ROW0_END  = addr_t'(COLUMNS - 1);
    localparam addr_t ROW1_END  = addr_t'(7'h40 + COLUMNS - 1);
    localparam addr_t ROW_SPAN  = addr_t'(COLUMNS);

    typedef enum logic [OP_W-1:0] {
        OP_PUTCHAR     = 3'd0,
        OP_CLEAR       = 3'd1,
        OP_HOME        = 3'd2,
        OP_ADVANCE     = 3'd3,
        OP_SHIFT_LEFT  = 3'd4,
        OP_SHIFT_RIGHT = 3'd5,
        OP_SET_CURSOR  = 3'd6
    } cmd_op_t;

    // one port set of the character store
    typedef struct packed {
        logic  we;
        idx_t  waddr;
        char_t wdata;
        logic  clr;
        idx_t  raddr;
    } ram_req_t;

    // per-cell flags that travel with a read
    typedef struct packed {
        logic    row;
        column_t column;
        logic    cursor_here;
        logic    last;
    } cell_info_t;

    function automatic logic addr_has_cell(input addr_t a, input logic single_row);
        logic in_row0;
        logic in_row1;
        in_row0 = (a < ROW_SPAN);
        in_row1 = !single_row && (a >= ROW1_BASE) && (a <= ROW1_END);
        return in_row0 || in_row1;
    endfunction

    function automatic idx_t addr_to_idx(input addr_t a);
        addr_t off;
        off = a - ROW1_BASE;
        return (a < ROW_SPAN) ? idx_t'(a) : idx_t'(COLUMNS) + idx_t'(off);
    endfunction

    function automatic idx_t cell_idx(input logic row, input col_t col);
        return row ? idx_t'(COLUMNS) + idx_t'(col) : idx_t'(col);
    endfunction

    function automatic addr_t cell_addr(input logic row, input col_t col);
        return row ? ROW1_BASE + addr_t'(col) : addr_t'(col);
    endfunction

    // cursor advance with wrap at each row end
    function automatic addr_t next_addr(input addr_t a);
        addr_t n;
        if (a == ROW0_END)
        begin
            n = '0;
        end
        else if (a == ROW1_END)
        begin
            n = ROW1_BASE;
        end
        else
        begin
            n = a + addr_t'(1);
        end
        return n;
    endfunction

endpackage

### src/cdbc_cmd_if.sv
// command channel of the display buffer controller
// depends on cdbc_pkg for field widths

interface cdbc_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [cdbc_pkg::OP_W-1:0]      op;
    logic [cdbc_pkg::CHAR_W-1:0]    character;
    logic [cdbc_pkg::ADDR_W-1:0]    address;

    modport source (output valid, output op, output character, output address, input ready);
    modport sink   (input valid, input op, input character, input address, output ready);
endinterface

### src/cdbc_cell_if.sv
// result channel: one beat per emitted display cell
// depends on cdbc_pkg for field widths

interface cdbc_cell_if;
    logic                           valid;
    logic                           ready;
    logic                           row;
    logic [cdbc_pkg::COLUMN_W-1:0]  column;
    logic [cdbc_pkg::CHAR_W-1:0]    glyph;
    logic                           cursor_here;
    logic                           last;

    modport source (output valid, output row, output column, output glyph,
                    output cursor_here, output last, input ready);
    modport sink   (input valid, input row, input column, input glyph,
                    input cursor_here, input last, output ready);
endinterface

### src/cdbc_cfg_if.sv
// configuration write channel carrying the single_row bit
// no package dependencies

interface cdbc_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/cdbc_cell_ram.sv
// character store: synchronous memory, one write and one read port, registered read
// per-entry valid bits give the reset/clear value; depends on cdbc_pkg

module cdbc_cell_ram
(
    input  logic                clk,
    input  logic                rst_n,
    input  cdbc_pkg::ram_req_t  req,
    output cdbc_pkg::char_t     glyph
);

    cdbc_pkg::char_t              cells_reg [cdbc_pkg::NCELLS];
    logic [cdbc_pkg::NCELLS-1:0]  valid_reg;
    cdbc_pkg::char_t              rd_data_reg;
    logic                         rd_valid_reg;
    logic                         fwd;

    // read of the entry being written returns the new data
    assign fwd = req.we && (req.waddr == req.raddr);

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            cells_reg[req.waddr] <= req.wdata;
        end
        rd_data_reg  <= fwd ? req.wdata : cells_reg[req.raddr];
        rd_valid_reg <= fwd ? 1'b1 : valid_reg[req.raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (req.clr)
        begin
            valid_reg <= '0;
        end
        else if (req.we)
        begin
            valid_reg[req.waddr] <= 1'b1;
        end
    end

    // never-written or cleared entries read as a space
    assign glyph = rd_valid_reg ? rd_data_reg : cdbc_pkg::SPACE;

endmodule

### src/cdbc_ctrl.sv
// command sequencer: cursor state, row shift read-modify-write, frame scan
// drives the character store port; depends on cdbc_pkg

module cdbc_ctrl
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    input  logic [cdbc_pkg::OP_W-1:0]   op,
    input  cdbc_pkg::char_t             character,
    input  cdbc_pkg::addr_t             address,
    input  logic                        single_row,
    input  logic                        out_ready,
    input  cdbc_pkg::char_t             glyph_rd,
    output logic                        cmd_ready,
    output cdbc_pkg::ram_req_t          ram_req,
    output logic                        out_valid,
    output cdbc_pkg::cell_info_t        out_info
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SHIFT = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_DRAIN = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    cdbc_pkg::addr_t        cursor_addr_reg, cursor_addr_next;
    logic                   cursor_shown_reg, cursor_shown_next;
    logic                   shift_right_reg, shift_right_next;
    logic                   shift_row_reg, shift_row_next;
    cdbc_pkg::col_t         shift_step_reg, shift_step_next;
    logic                   wr_pend_reg, wr_pend_next;
    cdbc_pkg::idx_t         wr_idx_reg, wr_idx_next;
    logic                   wr_space_reg, wr_space_next;
    logic                   scan_row_reg, scan_row_next;
    cdbc_pkg::col_t         scan_col_reg, scan_col_next;
    cdbc_pkg::idx_t         cur_idx_reg, cur_idx_next;
    logic                   out_valid_reg, out_valid_next;
    cdbc_pkg::cell_info_t   out_info_reg, out_info_next;

    logic                   accept;
    logic                   adv;
    logic                   do_place;
    cdbc_pkg::addr_t        place_tgt;
    cdbc_pkg::col_t         dest_col;
    cdbc_pkg::col_t         src_col;
    logic                   step_last;
    logic                   scan_last;
    cdbc_pkg::idx_t         scan_idx;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign accept    = cmd_valid && cmd_ready;
    assign adv       = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_info  = out_info_reg;

    // shift walks toward the vacated end so writes trail the reads
    assign step_last = (shift_step_reg == cdbc_pkg::LAST_COL);
    assign dest_col  = shift_right_reg ? (cdbc_pkg::LAST_COL - shift_step_reg) : shift_step_reg;
    assign src_col   = step_last ? dest_col :
                       (shift_right_reg ? (dest_col - cdbc_pkg::col_t'(1))
                                        : (dest_col + cdbc_pkg::col_t'(1)));

    assign scan_last = (scan_col_reg == cdbc_pkg::LAST_COL) && (scan_row_reg || single_row);
    assign scan_idx  = cdbc_pkg::cell_idx(scan_row_reg, scan_col_reg);

    always_comb
    begin
        state_next        = state_reg;
        cursor_addr_next  = cursor_addr_reg;
        cursor_shown_next = cursor_shown_reg;
        shift_right_next  = shift_right_reg;
        shift_row_next    = shift_row_reg;
        shift_step_next   = shift_step_reg;
        wr_pend_next      = 1'b0;
        wr_idx_next       = wr_idx_reg;
        wr_space_next     = wr_space_reg;
        scan_row_next     = scan_row_reg;
        scan_col_next     = scan_col_reg;
        cur_idx_next      = cur_idx_reg;
        out_valid_next    = out_valid_reg;
        out_info_next     = out_info_reg;
        do_place          = 1'b0;
        place_tgt         = cursor_addr_reg;

        ram_req.we    = wr_pend_reg;
        ram_req.waddr = wr_idx_reg;
        ram_req.wdata = wr_space_reg ? cdbc_pkg::SPACE : glyph_rd;
        ram_req.clr   = 1'b0;
        ram_req.raddr = cur_idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next    = ST_SCAN;
                    scan_row_next = 1'b0;
                    scan_col_next = '0;
                    case (cdbc_pkg::cmd_op_t'(op))
                        cdbc_pkg::OP_PUTCHAR:
                        begin
                            // write is dropped when the cursor address has no cell
                            if (cdbc_pkg::addr_has_cell(cursor_addr_reg, single_row))
                            begin
                                ram_req.we    = 1'b1;
                                ram_req.waddr = cdbc_pkg::addr_to_idx(cursor_addr_reg);
                                ram_req.wdata = character;
                            end
                            do_place  = 1'b1;
                            place_tgt = cdbc_pkg::next_addr(cursor_addr_reg);
                        end
                        cdbc_pkg::OP_CLEAR:
                        begin
                            ram_req.clr = 1'b1;
                        end
                        cdbc_pkg::OP_HOME:
                        begin
                            do_place  = 1'b1;
                            place_tgt = '0;
                        end
                        cdbc_pkg::OP_ADVANCE:
                        begin
                            do_place  = 1'b1;
                            place_tgt = cdbc_pkg::next_addr(cursor_addr_reg);
                        end
                        cdbc_pkg::OP_SHIFT_LEFT, cdbc_pkg::OP_SHIFT_RIGHT:
                        begin
                            state_next       = ST_SHIFT;
                            shift_right_next = (cdbc_pkg::cmd_op_t'(op) ==
                                                cdbc_pkg::OP_SHIFT_RIGHT);
                            shift_row_next   = 1'b0;
                            shift_step_next  = '0;
                        end
                        cdbc_pkg::OP_SET_CURSOR:
                        begin
                            do_place  = 1'b1;
                            place_tgt = address;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SHIFT:
            begin
                // read source now, write destination next cycle
                ram_req.raddr = cdbc_pkg::cell_idx(shift_row_reg, src_col);
                wr_pend_next  = 1'b1;
                wr_idx_next   = cdbc_pkg::cell_idx(shift_row_reg, dest_col);
                wr_space_next = step_last;
                if (step_last)
                begin
                    shift_step_next = '0;
                    if (!shift_row_reg && !single_row)
                    begin
                        shift_row_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
                else
                begin
                    shift_step_next = shift_step_reg + cdbc_pkg::col_t'(1);
                end
            end
            ST_SCAN:
            begin
                if (adv)
                begin
                    ram_req.raddr             = scan_idx;
                    cur_idx_next              = scan_idx;
                    out_valid_next            = 1'b1;
                    out_info_next.row         = scan_row_reg;
                    out_info_next.column      = cdbc_pkg::column_t'(scan_col_reg);
                    out_info_next.cursor_here = cursor_shown_reg &&
                        (cursor_addr_reg == cdbc_pkg::cell_addr(scan_row_reg, scan_col_reg));
                    out_info_next.last        = scan_last;
                    if (scan_last)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else if (scan_col_reg == cdbc_pkg::LAST_COL)
                    begin
                        scan_col_next = '0;
                        scan_row_next = 1'b1;
                    end
                    else
                    begin
                        scan_col_next = scan_col_reg + cdbc_pkg::col_t'(1);
                    end
                end
            end
            ST_DRAIN:
            begin
                if (adv)
                begin
                    out_valid_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (do_place)
        begin
            if (cdbc_pkg::addr_has_cell(place_tgt, single_row))
            begin
                cursor_addr_next  = place_tgt;
                cursor_shown_next = 1'b1;
            end
            else
            begin
                cursor_shown_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cursor_addr_reg  <= '0;
            cursor_shown_reg <= 1'b1;
            shift_right_reg  <= 1'b0;
            shift_row_reg    <= 1'b0;
            shift_step_reg   <= '0;
            wr_pend_reg      <= 1'b0;
            scan_row_reg     <= 1'b0;
            scan_col_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cursor_addr_reg  <= cursor_addr_next;
            cursor_shown_reg <= cursor_shown_next;
            shift_right_reg  <= shift_right_next;
            shift_row_reg    <= shift_row_next;
            shift_step_reg   <= shift_step_next;
            wr_pend_reg      <= wr_pend_next;
            scan_row_reg     <= scan_row_next;
            scan_col_reg     <= scan_col_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_idx_reg   <= wr_idx_next;
        wr_space_reg <= wr_space_next;
        cur_idx_reg  <= cur_idx_next;
        out_info_reg <= out_info_next;
    end

endmodule

### src/char_display_buffer_controller_unit.sv
// top level of the character display buffer controller
// depends on cdbc_pkg, the channel interfaces, cdbc_ctrl, cdbc_cell_ram, assert_macros.svh
//
//   channel  dir  fields                                      beats per command
//   cmd      in   op, character, address                      1
//   frame    out  row, column, glyph, cursor_here, last        16 or 32 (COLUMNS per row)
//   cfg      in   data (single_row)                           -
//
// one command at a time: cmd is taken only when the previous frame has fully drained
// non-shift commands go straight to the frame scan, which reads one cell per cycle from
// the character store unless the output stalls; shifts first read-modify-write each shown row
// reset clears the store's valid bits at once, so no clearing pass is needed
// a stalled cell beat holds: the store is re-read at the same entry until taken
`include "assert_macros.svh"

module char_display_buffer_controller_unit
(
    input  logic          clk,
    input  logic          rst_n,
    cdbc_cmd_if.sink      cmd,
    cdbc_cell_if.source   frame,
    cdbc_cfg_if.sink      cfg
);

    logic                   single_row_reg;
    cdbc_pkg::ram_req_t     ram_req;
    cdbc_pkg::char_t        glyph_rd;
    cdbc_pkg::cell_info_t   out_info;
    logic                   out_valid;
    logic                   cmd_ready;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            single_row_reg <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            single_row_reg <= cfg.data;
        end
    end

    cdbc_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd.valid),
        .op         (cmd.op),
        .character  (cmd.character),
        .address    (cmd.address),
        .single_row (single_row_reg),
        .out_ready  (frame.ready),
        .glyph_rd   (glyph_rd),
        .cmd_ready  (cmd_ready),
        .ram_req    (ram_req),
        .out_valid  (out_valid),
        .out_info   (out_info)
    );

    cdbc_cell_ram u_ram
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ram_req),
        .glyph (glyph_rd)
    );

    assign cmd.ready         = cmd_ready;
    assign frame.valid       = out_valid;
    assign frame.row         = out_info.row;
    assign frame.column      = out_info.column;
    assign frame.cursor_here = out_info.cursor_here;
    assign frame.last        = out_info.last;
    assign frame.glyph       = glyph_rd;

    // no new command while a frame is still on the output
    `ASSERT_IMPLIES(a_idle_no_beat, clk, rst_n, cmd.ready, !frame.valid)
    // an accepted command always makes the sequencer busy in the next cycle
    `ASSERT_NEXT(a_cmd_goes_busy, clk, rst_n, cmd.valid && cmd.ready, !cmd.ready)
    // frame beats run back to back until the last one
    `ASSERT_NEXT(a_frame_continues, clk, rst_n,
                 frame.valid && frame.ready && !frame.last, frame.valid)
    // taking the last beat ends the frame
    `ASSERT_NEXT(a_frame_ends, clk, rst_n,
                 frame.valid && frame.ready && frame.last, !frame.valid && cmd.ready)

endmodule

### dv/tb_char_display_buffer_controller_unit.sv
`timescale 1ns / 1ps
// self-checking bench for char_display_buffer_controller_unit: scripted and random commands
// against an in-bench display model. depends on cdbc_pkg and the cmd, cell and cfg interfaces

module tb_char_display_buffer_controller_unit;

    localparam logic [cdbc_pkg::OP_W-1:0] OP_UNUSED = 3'd7;
    localparam logic [5:0]      NO_CURSOR    = 6'h3F;
    localparam int              HOLD_CYCLES  = 300;
    localparam int              DRAIN_CYCLES = 40;
    localparam int              PHASE_CMDS   = 28;
    localparam int              SCRIPT_LEN   = 27;

    typedef struct packed {
        logic              row;
        cdbc_pkg::column_t column;
        cdbc_pkg::char_t   glyph;
        logic              cursor_here;
        logic              last;
    } cell_beat_t;

    // one scripted command; glyph0 and cursor_at are checked only where typed is set
    typedef struct packed {
        logic                      mode;
        logic [cdbc_pkg::OP_W-1:0] op;
        cdbc_pkg::char_t           ch;
        cdbc_pkg::addr_t           addr;
        logic                      typed;
        cdbc_pkg::char_t           glyph0;
        logic [5:0]                cursor_at;
    } script_row_t;

    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        '{1'b0, OP_UNUSED,                8'hFF, 7'h7F, 1'b1, 8'h20, 6'd0},
        '{1'b0, cdbc_pkg::OP_PUTCHAR,     8'h00, 7'h00, 1'b1, 8'h00, 6'd1},
        '{1'b0, cdbc_pkg::OP_PUTCHAR,     8'hFF, 7'h7F, 1'b0, 8'h00, NO_CURSOR},
        '{1'b0, cdbc_pkg::OP_SET_CURSOR,  8'h00, 7'h0F, 1'b1, 8'h00, 6'd15},
        '{1'b0, cdbc_pkg::OP_PUTCHAR,     8'h41, 7'h00, 1'b1, 8'h00, 6'd0},
        '{1'b0, cdbc_pkg::OP_SET_CURSOR,  8'h00, 7'h4F, 1'b1, 8'h00, 6'd31},
        '{1'b0, cdbc_pkg::OP_ADVANCE,     8'h00, 7'h00, 1'b1, 8'h00, 6'd16},
        '{1'b0, cdbc_pkg::OP_PUTCHAR,     8'h5A, 7'h00, 1'b0, 8'h00, NO_CURSOR},
        '{1'b0, cdbc_pkg::OP_SET_CURSOR,  8'h00, 7'h7F, 1'b1, 8'h00, NO_CURSOR},
        '{1'b0, cdbc_pkg::OP_PUTCHAR,     8'h33, 7'h00, 1'b1, 8'h00, 6'd18},
        '{1'b0, cdbc_pkg::OP_SET_CURSOR,  8'h00, 7'h10, 1'b1, 8'h00, NO_CURSOR},
        '{1'b0, cdbc_pkg::OP_ADVANCE,     8'h00, 7'h00, 1'b1, 8'h00, 6'd19},
        '{1'b0, cdbc_pkg::OP_SET_CURSOR,  8'h00, 7'h50, 1'b1, 8'h00, NO_CURSOR},
        '{1'b0, cdbc_pkg::OP_SHIFT_RIGHT, 8'h00, 7'h00, 1'b1, 8'h20, NO_CURSOR},
        '{1'b0, cdbc_pkg::OP_SHIFT_LEFT,  8'h00, 7'h00, 1'b1, 8'h00, NO_CURSOR},
        '{1'b0, cdbc_pkg::OP_HOME,        8'h00, 7'h00, 1'b1, 8'h00, 6'd0},
        '{1'b0, cdbc_pkg::OP_SET_CURSOR,  8'h00, 7'h45, 1'b1, 8'h00, 6'd21},
        '{1'b0, cdbc_pkg::OP_PUTCHAR,     8'hA5, 7'h00, 1'b0, 8'h00, NO_CURSOR},
        '{1'b0, cdbc_pkg::OP_CLEAR,       8'h00, 7'h00, 1'b1, 8'h20, 6'd22},
        '{1'b0, cdbc_pkg::OP_PUTCHAR,     8'h7E, 7'h00, 1'b0, 8'h00, NO_CURSOR},
        '{1'b1, OP_UNUSED,                8'h00, 7'h00, 1'b1, 8'h20, NO_CURSOR},
        '{1'b1, cdbc_pkg::OP_PUTCHAR,     8'h61, 7'h00, 1'b1, 8'h20, NO_CURSOR},
        '{1'b1, cdbc_pkg::OP_SHIFT_LEFT,  8'h00, 7'h00, 1'b0, 8'h00, NO_CURSOR},
        '{1'b1, cdbc_pkg::OP_SET_CURSOR,  8'h00, 7'h0F, 1'b1, 8'h20, 6'd15},
        '{1'b1, cdbc_pkg::OP_ADVANCE,     8'h00, 7'h00, 1'b1, 8'h20, 6'd0},
        '{1'b1, cdbc_pkg::OP_PUTCHAR,     8'h42, 7'h00, 1'b1, 8'h42, 6'd1},
        '{1'b0, OP_UNUSED,                8'h00, 7'h00, 1'b1, 8'h42, 6'd1}
    };

    logic clk;
    logic rst_n;

    cdbc_cmd_if  cmd_bus ();
    cdbc_cell_if cell_bus ();
    cdbc_cfg_if  cfg_bus ();

    char_display_buffer_controller_unit uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .frame (cell_bus),
        .cfg   (cfg_bus)
    );

    // display model state
    cdbc_pkg::char_t store [cdbc_pkg::NCELLS];
    cdbc_pkg::addr_t cur_addr;
    logic            cur_shown;
    logic            one_row;
    cell_beat_t      frame_buf [cdbc_pkg::NCELLS];
    int              frame_len;

    cell_beat_t pending_cells [$];
    cell_beat_t got;
    cell_beat_t want;
    int         mismatches;
    int         beats_checked;
    int         cmds_sent;
    int         burst_left;
    int         hold_asked;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int slot_of(input cdbc_pkg::addr_t a);
        if (a < cdbc_pkg::COLUMNS)
        begin
            return int'(a);
        end
        if (!one_row && a >= cdbc_pkg::ROW1_BASE &&
            int'(a) < int'(cdbc_pkg::ROW1_BASE) + cdbc_pkg::COLUMNS)
        begin
            return cdbc_pkg::COLUMNS + int'(a) - int'(cdbc_pkg::ROW1_BASE);
        end
        return -1;
    endfunction

    // an address without a cell hides the cursor but keeps the old address
    function automatic void place_cursor(input cdbc_pkg::addr_t a);
        if (slot_of(a) >= 0)
        begin
            cur_addr  = a;
            cur_shown = 1'b1;
        end
        else
        begin
            cur_shown = 1'b0;
        end
    endfunction

    function automatic void step_cursor();
        if (cur_addr == cdbc_pkg::addr_t'(cdbc_pkg::COLUMNS - 1))
        begin
            place_cursor('0);
        end
        else if (cur_addr == cdbc_pkg::ROW1_BASE + cdbc_pkg::addr_t'(cdbc_pkg::COLUMNS - 1))
        begin
            place_cursor(cdbc_pkg::ROW1_BASE);
        end
        else
        begin
            place_cursor(cur_addr + cdbc_pkg::addr_t'(1));
        end
    endfunction

    function automatic void shift_row(input int base, input logic right);
        if (right)
        begin
            for (int i = cdbc_pkg::COLUMNS - 1; i > 0; i--)
            begin
                store[base + i] = store[base + i - 1];
            end
            store[base] = cdbc_pkg::SPACE;
        end
        else
        begin
            for (int i = 0; i < cdbc_pkg::COLUMNS - 1; i++)
            begin
                store[base + i] = store[base + i + 1];
            end
            store[base + cdbc_pkg::COLUMNS - 1] = cdbc_pkg::SPACE;
        end
    endfunction

    // applies one command to the model and fills frame_buf with the cells it emits
    function automatic void render_frame(input logic [cdbc_pkg::OP_W-1:0] op,
                                         input cdbc_pkg::char_t ch,
                                         input cdbc_pkg::addr_t a);
        int              slot;
        int              rows;
        cdbc_pkg::addr_t here;
        case (op)
            cdbc_pkg::OP_PUTCHAR:
            begin
                slot = slot_of(cur_addr);
                if (slot >= 0)
                begin
                    store[slot] = ch;
                end
                step_cursor();
            end
            cdbc_pkg::OP_CLEAR:
            begin
                for (int i = 0; i < cdbc_pkg::NCELLS; i++)
                begin
                    store[i] = cdbc_pkg::SPACE;
                end
            end
            cdbc_pkg::OP_HOME:       place_cursor('0);
            cdbc_pkg::OP_ADVANCE:    step_cursor();
            cdbc_pkg::OP_SHIFT_LEFT, cdbc_pkg::OP_SHIFT_RIGHT:
            begin
                shift_row(0, op == cdbc_pkg::OP_SHIFT_RIGHT);
                if (!one_row)
                begin
                    shift_row(cdbc_pkg::COLUMNS, op == cdbc_pkg::OP_SHIFT_RIGHT);
                end
            end
            cdbc_pkg::OP_SET_CURSOR: place_cursor(a);
            default:       ;
        endcase

        rows      = one_row ? 1 : 2;
        frame_len = 0;
        for (int r = 0; r < rows; r++)
        begin
            for (int c = 0; c < cdbc_pkg::COLUMNS; c++)
            begin
                here = (r != 0) ? cdbc_pkg::ROW1_BASE + cdbc_pkg::addr_t'(c)
                                : cdbc_pkg::addr_t'(c);
                frame_buf[frame_len].row         = (r != 0);
                frame_buf[frame_len].column      = cdbc_pkg::column_t'(c);
                frame_buf[frame_len].glyph       = store[r * cdbc_pkg::COLUMNS + c];
                frame_buf[frame_len].cursor_here = cur_shown && (cur_addr == here);
                frame_buf[frame_len].last        = (r == rows - 1) &&
                                                   (c == cdbc_pkg::COLUMNS - 1);
                frame_len++;
            end
        end
    endfunction

    task automatic send_cmd(input logic [cdbc_pkg::OP_W-1:0] op, input cdbc_pkg::char_t ch,
                            input cdbc_pkg::addr_t a);
        int gap;
        if (burst_left == 0)
        begin
            gap        = $urandom_range(1, 5);
            burst_left = ($urandom_range(0, 4) == 0) ? 20 : $urandom_range(1, 8);
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        cmd_bus.valid     <= 1'b1;
        cmd_bus.op        <= op;
        cmd_bus.character <= ch;
        cmd_bus.address   <= a;
        do @(posedge clk); while (!cmd_bus.ready);
        render_frame(op, ch, a);
        for (int k = 0; k < frame_len; k++)
        begin
            pending_cells.push_back(frame_buf[k]);
        end
        cmds_sent++;
    endtask

    // stop offering commands until every expected cell has come back
    task automatic drain();
        cmd_bus.valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending_cells.size() != 0);
    endtask

    task automatic write_mode(input logic v);
        drain();
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= v;
        do @(posedge clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        one_row = v;
    endtask

    function automatic void check_field(input string name, input logic [7:0] exp,
                                        input logic [7:0] act);
        if (act !== exp)
        begin
            $error("%s: expected %0h, got %0h", name, exp, act);
            mismatches++;
        end
    endfunction

    // receiver: cycles through stall styles, plus a long hold-off on request
    initial
    begin
        int   hold_given;
        int   hold_left;
        logic [7:0] rx_cycle;
        hold_given     = 0;
        hold_left      = 0;
        rx_cycle       = '0;
        cell_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            rx_cycle++;
            if (!rst_n)
            begin
                cell_bus.ready <= 1'b0;
            end
            else if (hold_asked != hold_given)
            begin
                hold_given = hold_asked;
                hold_left  = HOLD_CYCLES;
                cell_bus.ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left--;
                cell_bus.ready <= 1'b0;
            end
            else
            begin
                case (rx_cycle[7:6])
                    2'd0:    cell_bus.ready <= 1'b1;
                    2'd1:    cell_bus.ready <= 1'($urandom_range(0, 1));
                    2'd2:    cell_bus.ready <= ($urandom_range(0, 3) == 0);
                    default: cell_bus.ready <= (rx_cycle[2:0] != 3'd5) && (rx_cycle[2:0] != 3'd6);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && cell_bus.valid && cell_bus.ready)
        begin
            got = '{cell_bus.row, cell_bus.column, cell_bus.glyph,
                    cell_bus.cursor_here, cell_bus.last};
            if (pending_cells.size() == 0)
            begin
                $error("cell beat row %0d column %0d with nothing expected", got.row, got.column);
                mismatches++;
            end
            else
            begin
                want = pending_cells.pop_front();
                check_field("row", 8'(want.row), 8'(got.row));
                check_field("column", 8'(want.column), 8'(got.column));
                check_field("glyph", want.glyph, got.glyph);
                check_field("cursor_here", 8'(want.cursor_here), 8'(got.cursor_here));
                check_field("last", 8'(want.last), 8'(got.last));
                beats_checked++;
            end
        end
    end

    initial
    begin
        script_row_t               step;
        logic [5:0]                flagged;
        logic [cdbc_pkg::OP_W-1:0] op;
        cdbc_pkg::char_t           ch;
        cdbc_pkg::addr_t           a;
        int                        pick;

        clk   = 1'b0;
        rst_n = 1'b0;
        cmd_bus.valid     = 1'b0;
        cmd_bus.op        = cdbc_pkg::OP_PUTCHAR;
        cmd_bus.character = '0;
        cmd_bus.address   = '0;
        cfg_bus.valid     = 1'b0;
        cfg_bus.data      = 1'b0;
        for (int i = 0; i < cdbc_pkg::NCELLS; i++)
        begin
            store[i] = cdbc_pkg::SPACE;
        end
        cur_addr      = '0;
        cur_shown     = 1'b1;
        one_row       = 1'b0;
        mismatches    = 0;
        beats_checked = 0;
        cmds_sent     = 0;
        burst_left    = 0;
        hold_asked    = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_mode(1'b0);

        for (int i = 0; i < SCRIPT_LEN; i++)
        begin
            step = SCRIPT[i];
            if (step.mode !== one_row)
            begin
                write_mode(step.mode);
            end
            send_cmd(step.op, step.ch, step.addr);
            if (step.typed)
            begin
                flagged = NO_CURSOR;
                for (int k = 0; k < frame_len; k++)
                begin
                    if (frame_buf[k].cursor_here)
                    begin
                        flagged = 6'(k);
                    end
                end
                if (frame_buf[0].glyph !== step.glyph0 || flagged !== step.cursor_at)
                begin
                    $error("scripted command %0d: expected glyph %0h cursor %0d, model has %0h %0d",
                           i, step.glyph0, step.cursor_at, frame_buf[0].glyph, flagged);
                    mismatches++;
                end
            end
        end

        // random phases alternate row mode, starting with single row
        for (int phase = 0; phase < 4; phase++)
        begin
            write_mode(!phase[0]);
            for (int j = 0; j < PHASE_CMDS; j++)
            begin
                if (phase == 1 && j == 6)
                begin
                    hold_asked <= hold_asked + 1;
                end
                if (phase == 2 && j == 14)
                begin
                    drain();
                end
                pick = $urandom_range(0, 99);
                ch   = cdbc_pkg::char_t'($urandom_range(0, 255));
                a    = cdbc_pkg::addr_t'($urandom_range(0, 127));
                if (pick < 40)
                begin
                    op = cdbc_pkg::OP_PUTCHAR;
                end
                else if (pick < 56)
                begin
                    op = cdbc_pkg::OP_SET_CURSOR;
                    // mostly land on a real cell, otherwise anywhere
                    if ($urandom_range(0, 3) != 0)
                    begin
                        a = cdbc_pkg::addr_t'($urandom_range(0, cdbc_pkg::COLUMNS - 1));
                        if (!one_row && $urandom_range(0, 1) == 1)
                        begin
                            a = a + cdbc_pkg::ROW1_BASE;
                        end
                    end
                end
                else if (pick < 66)
                begin
                    op = cdbc_pkg::OP_ADVANCE;
                end
                else if (pick < 72)
                begin
                    op = cdbc_pkg::OP_HOME;
                end
                else if (pick < 80)
                begin
                    op = cdbc_pkg::OP_SHIFT_LEFT;
                end
                else if (pick < 88)
                begin
                    op = cdbc_pkg::OP_SHIFT_RIGHT;
                end
                else if (pick < 94)
                begin
                    op = cdbc_pkg::OP_CLEAR;
                end
                else
                begin
                    op = OP_UNUSED;
                end
                send_cmd(op, ch, a);
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("ran %0d commands (%0d scripted) in both row modes, %0d cell beats compared",
                 cmds_sent, SCRIPT_LEN, beats_checked);
        $display("random output stalls, one %0d-cycle hold-off and one full drain included",
                 HOLD_CYCLES);
        if (mismatches == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
